// File: hdl/rmq_pkg.sv
// Shared types and constants for the rotation matrix to quaternion pipeline.
package rmq_pkg;

  localparam int DATA_W  = 16;
  localparam int FRAC    = 14;
  localparam int SQ_STEPS = 16;   // root bits, one per square-root cell
  localparam int DV_STEPS = 24;   // quotient bits, one per divide cell

  // Branch codes reported in case_taken
  localparam logic [1:0] BR_TRACE = 2'd0;
  localparam logic [1:0] BR_M11   = 2'd1;
  localparam logic [1:0] BR_M22   = 2'd2;
  localparam logic [1:0] BR_M33   = 2'd3;

  localparam logic [15:0] Q_MAX = 16'h7fff;
  localparam logic [15:0] Q_MIN = 16'h8000;

  // Data that rides alongside the arithmetic through every cell
  typedef struct packed {
    logic [1:0]        branch;
    logic              degen;
    logic [2:0][16:0]  diff;    // signed off-diagonal sums/differences, lane order
  } side_t;

  // Square-root cell state
  typedef struct packed {
    side_t       side;
    logic [31:0] rad;    // radicand, consumed two bits per cell from the top
    logic [16:0] rem;
    logic [15:0] root;
  } sqrt_t;

  // Divide cell state, three lanes sharing one divisor
  typedef struct packed {
    side_t            side;
    logic [15:0]      own;
    logic [16:0]      dvsr;
    logic [2:0][23:0] num;   // numerator bits still to shift in
    logic [2:0][16:0] prem;  // partial remainder
    logic [2:0][23:0] quo;
  } divs_t;

endpackage

// File: hdl/rotation_matrix_to_quaternion.sv
// Top level: rotation matrix to quaternion pipeline of square-root and divide cells.
//
//  channel | direction | tdata                          | tuser
//  in_     | slave     | 9 x Q2.14 matrix entries       | -
//  out_    | master    | quat w, x, y, z (Q2.14)        | case_taken, degenerate
//
// One matrix is taken every cycle while the output is not stalled; a result passes
// through the front stage, 16 square-root cells, prep stage, 24 divide cells and
// the output register. Every stage has its own valid bit, so bubbles close up
// while the output stalls. Reset clears the valid bits only.
module rotation_matrix_to_quaternion import rmq_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [143:0] in_tdata,   // elem_11..elem_13, elem_21..elem_23, elem_31..elem_33
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [63:0]  out_tdata,  // quat_w, quat_x, quat_y, quat_z
  output logic [2:0]   out_tuser   // case_taken[1:0], degenerate
);

  logic  sq_valid [SQ_STEPS+1];
  logic  sq_ready [SQ_STEPS+1];
  sqrt_t sq_data  [SQ_STEPS+1];
  logic  dv_valid [DV_STEPS+1];
  logic  dv_ready [DV_STEPS+1];
  divs_t dv_data  [DV_STEPS+1];

  rmq_front u_front (
    .clk, .rst_n,
    .in_valid (in_tvalid), .in_ready (in_tready), .in_data (in_tdata),
    .out_valid (sq_valid[0]), .out_ready (sq_ready[0]), .out_data (sq_data[0])
  );

  // Square-root chain
  for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sq
    rmq_sqrt_cell u_cell (
      .clk, .rst_n,
      .in_valid (sq_valid[i]), .in_ready (sq_ready[i]), .in_data (sq_data[i]),
      .out_valid (sq_valid[i+1]), .out_ready (sq_ready[i+1]),
      .out_data (sq_data[i+1])
    );
  end

  rmq_prep u_prep (
    .clk, .rst_n,
    .in_valid (sq_valid[SQ_STEPS]), .in_ready (sq_ready[SQ_STEPS]),
    .in_data (sq_data[SQ_STEPS]),
    .out_valid (dv_valid[0]), .out_ready (dv_ready[0]), .out_data (dv_data[0])
  );

  // Divide chain
  for (genvar i = 0; i < DV_STEPS; i++) begin : g_dv
    rmq_div_cell u_cell (
      .clk, .rst_n,
      .in_valid (dv_valid[i]), .in_ready (dv_ready[i]), .in_data (dv_data[i]),
      .out_valid (dv_valid[i+1]), .out_ready (dv_ready[i+1]),
      .out_data (dv_data[i+1])
    );
  end

  rmq_back u_back (
    .clk, .rst_n,
    .in_valid (dv_valid[DV_STEPS]), .in_ready (dv_ready[DV_STEPS]),
    .in_data (dv_data[DV_STEPS]),
    .out_valid (out_tvalid), .out_ready (out_tready),
    .out_data (out_tdata), .out_flags (out_tuser)
  );

`ifndef SYNTHESIS
  // Degenerate results carry a zero quaternion
  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[2] |-> out_tdata == 64'd0)
    else $error("degenerate result with non-zero quaternion");

  // The trace branch always has a positive argument
  a_trace_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1:0] == BR_TRACE |-> !out_tuser[2])
    else $error("trace branch flagged degenerate");

  // On the m11 branch, the component taken (x) is positive when not degenerate
  a_own_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[2] && out_tuser[1:0] == BR_M11 |->
      !out_tdata[31] && out_tdata[31:16] != 16'd0)
    else $error("own component not positive");
`endif

endmodule

// File: hdl/rmq_front.sv
// Input stage: trace, branch choice, square-root argument and lane differences.
module rmq_front import rmq_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [143:0] in_data,
  output logic         out_valid,
  input  logic         out_ready,
  output sqrt_t        out_data
);

  logic        valid_r;
  sqrt_t       data_r, data_nxt;
  logic signed [17:0] m11, m12, m13, m21, m22, m23, m31, m32, m33;
  logic signed [17:0] trace, arg;
  logic signed [17:0] d0, d1, d2;
  logic [1:0]         br;

  // Sign-extended matrix entries
  assign m11 = 18'(signed'(in_data[15:0]));
  assign m12 = 18'(signed'(in_data[31:16]));
  assign m13 = 18'(signed'(in_data[47:32]));
  assign m21 = 18'(signed'(in_data[63:48]));
  assign m22 = 18'(signed'(in_data[79:64]));
  assign m23 = 18'(signed'(in_data[95:80]));
  assign m31 = 18'(signed'(in_data[111:96]));
  assign m32 = 18'(signed'(in_data[127:112]));
  assign m33 = 18'(signed'(in_data[143:128]));
  assign trace = m11 + m22 + m33;

  // Branch choice; lanes hold the three non-own components in index order
  always_comb begin
    if (trace > 18'sd0) begin
      br  = BR_TRACE;
      arg = trace + 18'sd16384;
      d0 = m32 - m23; d1 = m13 - m31; d2 = m21 - m12;
    end else if (m11 > m22 && m11 > m33) begin
      br  = BR_M11;
      arg = 18'sd16384 + m11 - m22 - m33;
      d0 = m32 - m23; d1 = m12 + m21; d2 = m13 + m31;
    end else if (m22 > m33) begin
      br  = BR_M22;
      arg = 18'sd16384 + m22 - m11 - m33;
      d0 = m13 - m31; d1 = m12 + m21; d2 = m23 + m32;
    end else begin
      br  = BR_M33;
      arg = 18'sd16384 + m33 - m11 - m22;
      d0 = m21 - m12; d1 = m13 + m31; d2 = m23 + m32;
    end
  end

  always_comb begin
    data_nxt.side.branch  = br;
    data_nxt.side.degen   = (arg <= 18'sd0);
    data_nxt.side.diff[0] = d0[16:0];
    data_nxt.side.diff[1] = d1[16:0];
    data_nxt.side.diff[2] = d2[16:0];
    data_nxt.rad  = (arg <= 18'sd0) ? 32'd0 : {1'b0, arg[16:0], 14'd0};
    data_nxt.rem  = '0;
    data_nxt.root = '0;
  end

  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// File: hdl/rmq_sqrt_cell.sv
// One square-root cell: settles one root bit from the next two radicand bits.
module rmq_sqrt_cell import rmq_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  sqrt_t in_data,
  output logic  out_valid,
  input  logic  out_ready,
  output sqrt_t out_data
);

  logic        valid_r;
  sqrt_t       data_r, data_nxt;
  logic [18:0] r4, trial;
  logic        ge;

  // Trial subtraction of 4*root+1
  assign r4    = {in_data.rem, in_data.rad[31:30]};
  assign trial = {1'b0, in_data.root, 2'b01};
  assign ge    = (r4 >= trial);

  always_comb begin
    data_nxt      = in_data;
    data_nxt.rad  = {in_data.rad[29:0], 2'b00};
    data_nxt.rem  = ge ? 17'(r4 - trial) : r4[16:0];
    data_nxt.root = {in_data.root[14:0], ge};
  end

  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// File: hdl/rmq_prep.sv
// Root rounding, divisor and rounded numerators for the divide chain.
module rmq_prep import rmq_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  sqrt_t in_data,
  output logic  out_valid,
  input  logic  out_ready,
  output divs_t out_data
);

  logic        valid_r;
  divs_t       data_r, data_nxt;
  logic [15:0] root_rnd;
  logic [16:0] mag [3];
  logic [30:0] numer [3];

  // Round to nearest: remainder above root means the next integer is closer
  assign root_rnd = in_data.root + 16'(in_data.rem > {1'b0, in_data.root});

  always_comb begin
    data_nxt.side = in_data.side;
    data_nxt.own  = 16'((17'(root_rnd) + 17'd1) >> 1);
    data_nxt.dvsr = {root_rnd, 1'b0};
    for (int k = 0; k < 3; k++) begin
      mag[k] = in_data.side.diff[k][16] ? 17'(-in_data.side.diff[k])
                                         : in_data.side.diff[k];
      numer[k] = {mag[k], 14'd0} + 31'(root_rnd);
      data_nxt.num[k]  = numer[k][23:0];
      data_nxt.prem[k] = {10'd0, numer[k][30:24]};
      data_nxt.quo[k]  = '0;
    end
  end

  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// File: hdl/rmq_div_cell.sv
// One divide cell: one restoring quotient bit for each of the three lanes.
module rmq_div_cell import rmq_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  divs_t in_data,
  output logic  out_valid,
  input  logic  out_ready,
  output divs_t out_data
);

  logic        valid_r;
  divs_t       data_r, data_nxt;
  logic [17:0] t [3];
  logic        ge [3];

  always_comb begin
    data_nxt = in_data;
    for (int k = 0; k < 3; k++) begin
      t[k]  = {in_data.prem[k], in_data.num[k][23]};
      ge[k] = (t[k] >= {1'b0, in_data.dvsr});
      data_nxt.prem[k] = ge[k] ? 17'(t[k] - {1'b0, in_data.dvsr}) : t[k][16:0];
      data_nxt.num[k]  = {in_data.num[k][22:0], 1'b0};
      data_nxt.quo[k]  = {in_data.quo[k][22:0], ge[k]};
    end
  end

  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// File: hdl/rmq_back.sv
// Output stage: sign, saturation, component placement and the output register.
module rmq_back import rmq_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  divs_t       in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_data,
  output logic [2:0]  out_flags
);

  logic        valid_r;
  logic [63:0] data_r, data_nxt;
  logic [2:0]  flags_r, flags_nxt;
  logic [15:0] lane [3];
  logic [15:0] comp [4];
  logic [1:0]  br;

  assign br = in_data.side.branch;

  // Signed saturation of each lane quotient
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (in_data.side.diff[k][16]) begin
        lane[k] = (in_data.quo[k] > 24'd32768) ? Q_MIN
                                               : 16'(24'd0 - in_data.quo[k]);
      end else begin
        lane[k] = (in_data.quo[k] > 24'd32767) ? Q_MAX : in_data.quo[k][15:0];
      end
    end
  end

  // Own component at its branch index, lanes fill the rest in order
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      if (in_data.side.degen) begin
        comp[k] = '0;
      end else if (2'(k) == br) begin
        comp[k] = in_data.own;
      end else if (2'(k) < br) begin
        comp[k] = lane[k];
      end else begin
        comp[k] = lane[k-1];
      end
    end
    data_nxt  = {comp[3], comp[2], comp[1], comp[0]};
    flags_nxt = {in_data.side.degen, br};
  end

  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r  <= data_nxt;
      flags_r <= flags_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;
  assign out_flags = flags_r;

endmodule

// File: verif/rotation_matrix_to_quaternion_test.sv
// Testbench for the rotation matrix to quaternion block: random and directed matrices, scoreboarded.
module rotation_matrix_to_quaternion_test import rmq_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [15:0] w, x, y, z;
    logic [1:0]         branch;
    logic               degen;
  } quat_t;

  // Nearest integer square root
  function automatic longint unsigned isqrt_near(longint unsigned v);
    longint unsigned r, b, rem;
    r = 0; b = 64'd1 << 62; rem = v;
    while (b > rem) b >>= 2;
    while (b != 0) begin
      if (rem >= r + b) begin
        rem -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    if (r * r + r < v) r++;
    return r;
  endfunction

  // round(diff * 2^FRAC / s), half away from zero
  function automatic longint quot_round(longint diff, longint unsigned s);
    longint unsigned mag, q;
    mag = (diff < 0) ? longint'(-diff) : diff;
    q = ((mag << FRAC) + (s >> 1)) / s;
    return (diff < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic [15:0] clamp16(longint v);
    if (v > 32767) return Q_MAX;
    if (v < -32768) return Q_MIN;
    return v[15:0];
  endfunction

  function automatic quat_t predict_quat(logic [143:0] d);
    longint m [9];
    longint tr, arg, df [4], q [4];
    longint unsigned root;
    logic [1:0] br;
    quat_t r;
    for (int i = 0; i < 9; i++) m[i] = longint'($signed(d[16*i +: 16]));
    tr = m[0] + m[4] + m[8];
    for (int k = 0; k < 4; k++) begin q[k] = 0; df[k] = 0; end
    if (tr > 0) begin
      br = BR_TRACE; arg = tr + (1 << FRAC);
      df[1] = m[7] - m[5]; df[2] = m[2] - m[6]; df[3] = m[3] - m[1];
    end else if (m[0] > m[4] && m[0] > m[8]) begin
      br = BR_M11; arg = (1 << FRAC) + m[0] - m[4] - m[8];
      df[0] = m[7] - m[5]; df[2] = m[1] + m[3]; df[3] = m[2] + m[6];
    end else if (m[4] > m[8]) begin
      br = BR_M22; arg = (1 << FRAC) + m[4] - m[0] - m[8];
      df[0] = m[2] - m[6]; df[1] = m[1] + m[3]; df[3] = m[5] + m[7];
    end else begin
      br = BR_M33; arg = (1 << FRAC) + m[8] - m[0] - m[4];
      df[0] = m[3] - m[1]; df[1] = m[2] + m[6]; df[2] = m[5] + m[7];
    end
    r.degen = (arg <= 0);
    if (!r.degen) begin
      root = isqrt_near(longint'(arg) << FRAC);
      for (int k = 0; k < 4; k++)
        q[k] = (k == br) ? longint'((root + 1) >> 1) : quot_round(df[k], root << 1);
    end
    r.w = clamp16(q[0]); r.x = clamp16(q[1]); r.y = clamp16(q[2]); r.z = clamp16(q[3]);
    r.branch = br;
    return r;
  endfunction

  // Expected quaternions in transfer order
  class quat_scoreboard;
    quat_t pending [$];
    int    errors;
    function void note_matrix(logic [143:0] d);
      pending.push_back(predict_quat(d));
    endfunction
    function void check_quat(logic [63:0] td, logic [2:0] tu);
      quat_t got, want;
      got = {td[15:0], td[31:16], td[47:32], td[63:48], tu[1:0], tu[2]};
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h %h", td, tu);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10)
          $display("w/x/y/z/br/dg exp %h %h %h %h %0d %0d got %h %h %h %h %0d %0d",
                   want.w, want.x, want.y, want.z, want.branch, want.degen,
                   got.w, got.x, got.y, got.z, got.branch, got.degen);
      end
    endfunction
  endclass

  logic         clk, rst_n;
  logic         in_tvalid, in_tready, out_tvalid, out_tready;
  logic [143:0] in_tdata;
  logic [63:0]  out_tdata;
  logic [2:0]   out_tuser;
  quat_scoreboard sb;

  rotation_matrix_to_quaternion u_dut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("Mismatches found");
    $finish;
  end

  // One matrix transfer, with a random gap before it
  task automatic send_matrix(logic [143:0] d);
    int gap;
    gap = $urandom_range(0, 4);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_matrix(d);
    @(negedge clk);
  endtask

  function automatic logic [15:0] pick_elem();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h4000;
      3: return 16'hc000;
      4: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  // Roughly orthonormal matrix: signed permutation with jitter
  function automatic logic [143:0] near_rotation();
    logic [143:0] d;
    int p [3], t, s;
    p = '{0, 1, 2};
    for (int i = 2; i > 0; i--) begin
      t = $urandom_range(0, i); s = p[i]; p[i] = p[t]; p[t] = s;
    end
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++) begin
        s = $urandom_range(0, 2000) - 1000;
        if (p[r] == c) s += ($urandom_range(0, 1) ? 16384 : -16384) - (s > 0 ? s : -s);
        else s = s * ($urandom_range(0, 8));
        d[16*(3*r + c) +: 16] = s[15:0];
      end
    return d;
  endfunction

  // Receiver: random stall before each result
  initial begin
    int gap;
    out_tready = 1'b0;
    forever begin
      gap = $urandom_range(0, 4);
      if (gap != 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      sb.check_quat(out_tdata, out_tuser);
      @(negedge clk);
    end
  end

  initial begin
    logic [143:0] d;
    int wait_cyc;
    sb = new();
    rst_n = 1'b0; in_tvalid = 1'b0; in_tdata = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    // Directed: identity, extremes, each branch, degenerate arguments
    send_matrix({16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'sd0,
                 16'sd16384});
    send_matrix({9{16'h8000}});
    send_matrix({9{16'h7fff}});
    send_matrix({9{16'hffff}});
    send_matrix('0);
    send_matrix({16'hc000, 16'h0, 16'h0, 16'h0, 16'hc000, 16'h0, 16'h0, 16'h0, 16'h4000});
    send_matrix({16'hc000, 16'h0, 16'h0, 16'h0, 16'h4000, 16'h0, 16'h0, 16'h0, 16'hc000});
    send_matrix({16'h4000, 16'h0, 16'h0, 16'h0, 16'hc000, 16'h0, 16'h0, 16'h0, 16'hc000});
    // ties on the diagonal
    send_matrix({16'hc000, 16'h1234, 16'h0, 16'h0, 16'hc000, 16'h0, 16'h5678, 16'h0, 16'hc000});
    send_matrix({16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff,
                 16'h8000});
    send_matrix({16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000,
                 16'h8000});
    for (int i = 0; i < 8; i++) begin
      for (int k = 0; k < 9; k++) d[16*k +: 16] = pick_elem();
      send_matrix(d);
    end
    // Random: mostly near-rotations, the rest picked extremes or raw bit patterns
    for (int i = 0; i < 1330; i++) begin
      if ($urandom_range(0, 9) < 6) d = near_rotation();
      else if ($urandom_range(0, 1)) for (int k = 0; k < 9; k++) d[16*k +: 16] = pick_elem();
      else d = 144'({$urandom, $urandom, $urandom, $urandom, $urandom});
      send_matrix(d);
    end
    in_tvalid <= 1'b0;
    wait_cyc = 0;
    while (sb.pending.size() != 0 && wait_cyc < 100000) begin
      @(posedge clk);
      wait_cyc++;
    end
    repeat (60) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
